// ----- design/cbid_pkg.sv -----
// ----------------------------------------------------------------------------
// Dispatch stage package
// Transaction types, operation and unit codes, and parameter defaults shared
// by the dispatch core, its channels and its test environment.
// ----------------------------------------------------------------------------
package cbid_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_WIDTH_DEF   = 8;
  localparam int TAG_BITS_DEF    = 8;

  localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
  localparam logic [1:0] FUNC_CREDIT  = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;
  localparam logic [1:0] FUNC_FLUSH   = 2'd3;

  localparam logic [2:0] UNIT_ROB   = 3'd5;
  localparam logic [2:0] STALL_NONE = 3'd0;

  localparam logic [7:0] CREDIT_MAX           = 8'd255;
  localparam logic [3:0] DISPATCH_WIDTH_RESET = 4'd4;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] target_unit;
    logic [7:0] inst_tag;
    logic [3:0] credit_amount;
  } instr_item_t;

  typedef struct packed {
    logic       inst_valid;
    logic [7:0] out_tag;
    logic [2:0] dest_unit;
    logic [2:0] stall_code;
    logic [4:0] upstream_credits;
    logic       enqueue_dropped;
    logic       last;
  } result_item_t;

endpackage

// ----- design/cbid_stream_if.sv -----
// ----------------------------------------------------------------------------
// Valid/ready stream channel
// Carries one transaction per clock edge at which valid and ready are high.
// ----------------------------------------------------------------------------
interface cbid_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- design/credit_based_instruction_dispatch_core.sv -----
// Enqueue and flush go straight to the result stage; a credit return first
// passes the credit update state. A dispatch tick scans its candidates through
// the walk and check states, then emits each dispatched instruction through
// RAM read, build and output register. Transactions are taken one at a time;
// the sequencer holds the input off until a transaction's last result is loaded.
// Synchronous reset empties the queue, clears all credits and the stall
// reason, and sets the dispatch width to 4; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Credit-based in-order dispatch core
// Keeps an instruction queue in RAM and credit pools per execution unit.
// A tick checks credits in a first pass, then emits results in a second.
// ----------------------------------------------------------------------------
module credit_based_instruction_dispatch_core import cbid_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  cbid_stream_if.sink         instr,
  cbid_stream_if.source       result,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data
);

  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SENT_W     = $clog2(MAX_WIDTH + 1);
  localparam int LW0        = (CNT_W > SENT_W) ? CNT_W : SENT_W;
  localparam int LW         = (LW0 > 4) ? LW0 : 4;
  localparam int STORE_BITS = (TAG_BITS < 8) ? TAG_BITS : 8;
  localparam int ENTRY_W    = STORE_BITS + 3;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CREDIT = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_FETCH  = 3'd4;
  localparam logic [2:0] S_BUILD  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]            state;
  instr_item_t           item;
  logic [3:0]            dispatch_width;
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      ptr;
  logic [CNT_W-1:0]      count;
  logic [SENT_W-1:0]     sent;
  logic [SENT_W-1:0]     idx;
  logic [7:0]            unit_credits [5];
  logic [7:0]            reorder_credits;
  logic [2:0]            stall_reason;
  result_item_t          res;
  result_item_t          out_q;
  logic                  out_valid;

  logic                  we;
  logic [PTR_W-1:0]      tail;
  logic [PTR_W:0]        tail_sum;
  logic [PTR_W-1:0]      raddr;
  logic [ENTRY_W-1:0]    wdata;
  logic [ENTRY_W-1:0]    rdata;
  logic [2:0]            rd_unit;
  logic [STORE_BITS-1:0] rd_tag;
  logic [2:0]            in_unit;
  logic                  queue_full;
  logic [LW-1:0]         width_eff;
  logic                  walk_go;
  logic                  last_build;
  logic                  out_free;
  logic                  load;

  logic [2:0]            sel_unit;
  logic                  sel_is_unit;
  logic [7:0]            pool;
  logic [8:0]            sum;
  logic [7:0]            alu_out;
  logic                  stall_hit;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic result_item_t plain_result(input logic dropped,
                                                input logic [4:0] freed,
                                                input logic [2:0] stall);
    result_item_t r;
    r = '0;
    r.enqueue_dropped  = dropped;
    r.upstream_credits = freed;
    r.stall_code       = stall;
    r.last             = 1'b1;
    return r;
  endfunction

  assign tail_sum   = {1'b0, head} + (PTR_W + 1)'(count);
  assign tail       = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) ?
                      PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH)) :
                      tail_sum[PTR_W-1:0];
  assign queue_full = count >= CNT_W'(QUEUE_DEPTH);
  assign in_unit    = (instr.payload.target_unit > UNIT_ROB) ?
                      UNIT_ROB : instr.payload.target_unit;

  assign we    = (state == S_IDLE) && instr.valid &&
                 (instr.payload.func == FUNC_ENQUEUE) && !queue_full;
  assign wdata = {in_unit, instr.payload.inst_tag[STORE_BITS-1:0]};
  assign raddr = (state == S_WALK) ? ptr : head;

  assign rd_unit = rdata[ENTRY_W-1 -: 3];
  assign rd_tag  = rdata[STORE_BITS-1:0];

  cbid_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (we),
    .waddr (tail),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign width_eff  = (LW'(dispatch_width) > LW'(MAX_WIDTH)) ?
                      LW'(MAX_WIDTH) : LW'(dispatch_width);
  assign walk_go    = (LW'(sent) < width_eff) && (LW'(sent) < LW'(count)) &&
                      (reorder_credits != 8'd0);
  assign last_build = (LW'(idx) + LW'(1)) == LW'(sent);

  // Shared credit unit: saturating add on a return, decrement on a dispatch.
  assign sel_unit    = (state == S_CREDIT) ? item.target_unit : rd_unit;
  assign sel_is_unit = sel_unit < UNIT_ROB;
  assign pool        = sel_is_unit ? unit_credits[sel_unit] : reorder_credits;
  assign sum         = {1'b0, pool} + 9'(item.credit_amount);
  assign alu_out     = (state == S_CREDIT) ?
                       ((sum > 9'(CREDIT_MAX)) ? CREDIT_MAX : sum[7:0]) :
                       pool - 8'd1;
  assign stall_hit   = sel_is_unit && (pool == 8'd0);

  assign out_free = !out_valid || result.ready;
  assign load     = (state == S_EMIT) && out_free;

  assign instr.ready    = (state == S_IDLE);
  assign result.valid   = out_valid;
  assign result.payload = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      head            <= '0;
      ptr             <= '0;
      count           <= '0;
      sent            <= '0;
      idx             <= '0;
      for (int i = 0; i < 5; i++) begin
        unit_credits[i] <= 8'd0;
      end
      reorder_credits <= 8'd0;
      stall_reason    <= STALL_NONE;
      dispatch_width  <= DISPATCH_WIDTH_RESET;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dispatch_width <= cfg_wr_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (instr.valid) begin
            item <= instr.payload;
            unique case (instr.payload.func)
              FUNC_ENQUEUE: begin
                res <= plain_result(queue_full, 5'd0, stall_reason);
                if (!queue_full) begin
                  count <= count + 1'b1;
                end
                state <= S_EMIT;
              end
              FUNC_CREDIT: begin
                state <= S_CREDIT;
              end
              FUNC_TICK: begin
                sent  <= '0;
                ptr   <= head;
                state <= S_WALK;
              end
              FUNC_FLUSH: begin
                res   <= plain_result(1'b0, 5'(count), stall_reason);
                count <= '0;
                head  <= '0;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_CREDIT: begin
          if (item.target_unit < UNIT_ROB) begin
            unit_credits[item.target_unit] <= alu_out;
          end else if (item.target_unit == UNIT_ROB) begin
            reorder_credits <= alu_out;
          end
          res   <= plain_result(1'b0, 5'd0, stall_reason);
          state <= S_EMIT;
        end
        S_WALK: begin
          if (walk_go) begin
            if (sent == '0) begin
              stall_reason <= STALL_NONE;
            end
            state <= S_CHECK;
          end else begin
            idx   <= '0;
            state <= S_FETCH;
          end
        end
        S_CHECK: begin
          if (stall_hit) begin
            stall_reason <= rd_unit + 3'd1;
            idx          <= '0;
            state        <= S_FETCH;
          end else begin
            if (sel_is_unit) begin
              unit_credits[rd_unit] <= alu_out;
            end
            reorder_credits <= reorder_credits - 8'd1;
            sent            <= sent + 1'b1;
            ptr             <= ptr_inc(ptr);
            state           <= S_WALK;
          end
        end
        S_FETCH: begin
          if (sent == '0) begin
            res   <= plain_result(1'b0, 5'd0, stall_reason);
            state <= S_EMIT;
          end else begin
            state <= S_BUILD;
          end
        end
        S_BUILD: begin
          res.inst_valid       <= 1'b1;
          res.out_tag          <= 8'(rd_tag);
          res.dest_unit        <= rd_unit;
          res.stall_code       <= stall_reason;
          res.upstream_credits <= last_build ? 5'(sent) : 5'd0;
          res.enqueue_dropped  <= 1'b0;
          res.last             <= last_build;
          state                <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_q <= res;
            if (res.inst_valid) begin
              head  <= ptr_inc(head);
              count <= count - 1'b1;
              idx   <= idx + 1'b1;
            end
            state <= res.last ? S_IDLE : S_FETCH;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    instr.valid && instr.ready |=> state != S_IDLE)
    else $error("accepted transaction not taken up by the sequencer");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> LW'(sent) < width_eff)
    else $error("credit scan beyond dispatch width");

  a_dispatch_uses_reorder: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK && !stall_hit |=>
    reorder_credits == $past(reorder_credits) - 8'd1)
    else $error("dispatch did not consume a reorder credit");

  a_emit_pops: assert property (@(posedge clk) disable iff (rst)
    load && res.inst_valid |=> count == $past(count) - 1'b1)
    else $error("dispatched result did not pop the queue");

endmodule

// ----- design/cbid_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/credit_based_instruction_dispatch_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dispatch core self-checking test
// Drives enqueue, credit return, dispatch tick and flush transactions into the
// dispatch core over its valid/ready channels, with random gaps on both sides
// and a long receiver hold-off. A behavioural copy of the queue and credit
// pools predicts each result (or a directed row gives it); all are compared
// field by field in order. A short table of directed rows comes first, then
// random phases that move the dispatch width through its extremes.
// ----------------------------------------------------------------------------
module credit_based_instruction_dispatch_core_test;
  import cbid_pkg::*;

  localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int MAX_WIDTH   = MAX_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 24;

  localparam logic [2:0] UNIT_FPU    = 3'd0;
  localparam logic [2:0] UNIT_ALU0   = 3'd1;
  localparam logic [2:0] UNIT_ALU1   = 3'd2;
  localparam logic [2:0] UNIT_BRANCH = 3'd3;
  localparam logic [2:0] UNIT_LSU    = 3'd4;
  localparam logic [2:0] UNIT_SPARE6 = 3'd6;
  localparam logic [2:0] UNIT_SPARE7 = 3'd7;
  localparam logic [2:0] STALL_FPU   = 3'd1;

  typedef struct {
    bit           is_cfg;
    logic [3:0]   width;
    instr_item_t  item;
    bit           typed;
    result_item_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [3:0] cfg_wr_data;

  cbid_stream_if #(.payload_t(instr_item_t))  instr_ch ();
  cbid_stream_if #(.payload_t(result_item_t)) result_ch ();

  credit_based_instruction_dispatch_core dut (
    .clk         (clk),
    .rst         (rst),
    .instr       (instr_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Predicted state of the dispatch stage.
  logic [7:0]  slot_tag [QUEUE_DEPTH];
  logic [2:0]  slot_unit [QUEUE_DEPTH];
  int unsigned q_head;
  int unsigned q_count;
  logic [7:0]  unit_credit [5];
  logic [7:0]  rob_credit;
  logic [2:0]  stall_now;
  logic [3:0]  width_now;

  result_item_t expected_results [$];
  stim_row_t    directed_rows [$];

  int unsigned cycle_count = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int dispatched_seen = 0;
  int drops_seen = 0;
  int stalled_seen = 0;
  int unsigned peak_occupancy = 0;
  int send_idle_pct = 27;
  int ready_idle_pct = 27;
  logic hold_request = 1'b0;
  logic hold_off = 1'b0;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) $display("MISMATCH %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  function automatic instr_item_t mk_item(input logic [1:0] f, input logic [2:0] u,
                                          input logic [7:0] t, input logic [3:0] a);
    instr_item_t it;
    it.func = f;
    it.target_unit = u;
    it.inst_tag = t;
    it.credit_amount = a;
    return it;
  endfunction

  function automatic result_item_t quiet_result(input logic [2:0] stall,
                                                input logic [4:0] freed,
                                                input logic dropped);
    result_item_t r;
    r = '0;
    r.stall_code = stall;
    r.upstream_credits = freed;
    r.enqueue_dropped = dropped;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void add_item(input instr_item_t it);
    stim_row_t row;
    row = '{default: '0};
    row.item = it;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(input instr_item_t it, input result_item_t want);
    stim_row_t row;
    row = '{default: '0};
    row.item = it;
    row.typed = 1'b1;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_width(input logic [3:0] w);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.width = w;
    directed_rows.push_back(row);
  endfunction

  function automatic instr_item_t random_item(input int credit_pct);
    instr_item_t it;
    int unsigned r;
    it.target_unit = ($urandom_range(99) < 85) ? 3'($urandom_range(5)) : 3'($urandom_range(7));
    it.inst_tag = 8'($urandom_range(255));
    it.credit_amount = 4'($urandom_range(15));
    r = $urandom_range(99);
    if (r < credit_pct) begin
      it.func = FUNC_CREDIT;
    end else begin
      r = $urandom_range(99);
      it.func = (r < 55) ? FUNC_ENQUEUE : (r < 95) ? FUNC_TICK : FUNC_FLUSH;
    end
    return it;
  endfunction

  task automatic predict_dispatch(input instr_item_t it, input bit typed,
                                  input result_item_t want);
    result_item_t r;
    logic [7:0] sent_tag [MAX_WIDTH];
    logic [2:0] sent_unit [MAX_WIDTH];
    logic [2:0] u;
    int unsigned n;
    int unsigned sent;
    int unsigned slot;
    int unsigned total;
    bit blocked;
    r = '0;
    r.last = 1'b1;
    sent = 0;
    case (it.func)
      FUNC_ENQUEUE: begin
        if (q_count >= QUEUE_DEPTH) begin
          r.enqueue_dropped = 1'b1;
        end else begin
          slot = (q_head + q_count) % QUEUE_DEPTH;
          slot_tag[slot] = it.inst_tag;
          slot_unit[slot] = (it.target_unit > UNIT_ROB) ? UNIT_ROB : it.target_unit;
          q_count++;
          if (q_count > peak_occupancy) peak_occupancy = q_count;
        end
      end
      FUNC_CREDIT: begin
        if (it.target_unit < UNIT_ROB) begin
          total = unit_credit[it.target_unit] + it.credit_amount;
          unit_credit[it.target_unit] = (total > CREDIT_MAX) ? CREDIT_MAX : total[7:0];
        end else if (it.target_unit == UNIT_ROB) begin
          total = rob_credit + it.credit_amount;
          rob_credit = (total > CREDIT_MAX) ? CREDIT_MAX : total[7:0];
        end
      end
      FUNC_FLUSH: begin
        r.upstream_credits = q_count[4:0];
        q_count = 0;
        q_head = 0;
      end
      default: begin
        n = (width_now > MAX_WIDTH) ? MAX_WIDTH : width_now;
        if (q_count < n) n = q_count;
        if (rob_credit < n) n = rob_credit;
        if (n > 0) begin
          stall_now = STALL_NONE;
          blocked = 1'b0;
          while (!blocked && sent < n) begin
            u = slot_unit[q_head];
            if (u < UNIT_ROB && unit_credit[u] == 0) begin
              stall_now = u + 3'd1;
              blocked = 1'b1;
            end else begin
              if (u < UNIT_ROB) unit_credit[u]--;
              sent_tag[sent] = slot_tag[q_head];
              sent_unit[sent] = u;
              sent++;
              q_head = (q_head + 1) % QUEUE_DEPTH;
              q_count--;
              rob_credit--;
            end
          end
        end
      end
    endcase
    r.stall_code = stall_now;
    if (typed) begin
      expected_results.push_back(want);
    end else if (sent == 0) begin
      expected_results.push_back(r);
    end else begin
      for (int i = 0; i < sent; i++) begin
        r.inst_valid = 1'b1;
        r.out_tag = sent_tag[i];
        r.dest_unit = sent_unit[i];
        r.last = (i + 1 == sent);
        r.upstream_credits = r.last ? sent[4:0] : 5'd0;
        expected_results.push_back(r);
      end
    end
  endtask

  task automatic send_item(input instr_item_t it, input bit typed, input result_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    instr_ch.valid <= 1'b1;
    instr_ch.payload <= it;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
    predict_dispatch(it, typed, want);
    items_sent++;
  endtask

  task automatic drain_results();
    instr_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_width(input logic [3:0] w);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_now = w;
  endtask

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (hold_off) result_ch.ready <= 1'b0;
    else result_ch.ready <= ($urandom_range(99) >= ready_idle_pct);
  end

  initial begin : receiver_hold
    int held;
    wait (hold_request);
    @(posedge clk);
    hold_off <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : result_monitor
    result_item_t got;
    result_item_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.payload;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected: %h",
                                  results_seen, got));
      end else begin
        want = expected_results.pop_front();
        check_field("inst_valid", 8'(got.inst_valid), 8'(want.inst_valid));
        check_field("out_tag", got.out_tag, want.out_tag);
        check_field("dest_unit", 8'(got.dest_unit), 8'(want.dest_unit));
        check_field("stall_code", 8'(got.stall_code), 8'(want.stall_code));
        check_field("upstream_credits", 8'(got.upstream_credits),
                    8'(want.upstream_credits));
        check_field("enqueue_dropped", 8'(got.enqueue_dropped),
                    8'(want.enqueue_dropped));
        check_field("last", 8'(got.last), 8'(want.last));
      end
      if (got.inst_valid === 1'b1) dispatched_seen++;
      if (got.enqueue_dropped === 1'b1) drops_seen++;
      if (got.stall_code !== STALL_NONE) stalled_seen++;
      results_seen++;
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, expected_results.size());
    $display("FAIL credit_based_instruction_dispatch_core");
    $finish;
  end

  initial begin : stimulus
    result_item_t none;
    logic [3:0] w;
    int quota;
    int done;
    int burst;
    int credit_pct;
    logic [2:0] pool;

    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    instr_ch.valid <= 1'b0;
    instr_ch.payload <= '0;
    none = '0;
    q_head = 0;
    q_count = 0;
    rob_credit = '0;
    stall_now = STALL_NONE;
    width_now = DISPATCH_WIDTH_RESET;
    for (int i = 0; i < 5; i++) unit_credit[i] = '0;

    add_typed(mk_item(FUNC_TICK, UNIT_FPU, 8'h00, 4'h0),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_FLUSH, UNIT_FPU, 8'h00, 4'h0),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_ENQUEUE, UNIT_FPU, 8'hFF, 4'hF),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_ENQUEUE, UNIT_SPARE7, 8'h00, 4'h0),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_ENQUEUE, UNIT_SPARE6, 8'hA5, 4'h5),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_TICK, UNIT_FPU, 8'h00, 4'h0),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_CREDIT, UNIT_ROB, 8'h00, 4'hF),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_TICK, UNIT_FPU, 8'h00, 4'h0),
              quiet_result(STALL_FPU, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_CREDIT, UNIT_SPARE7, 8'h00, 4'hF),
              quiet_result(STALL_FPU, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_CREDIT, UNIT_FPU, 8'h00, 4'h1),
              quiet_result(STALL_FPU, 5'd0, 1'b0));
    add_item(mk_item(FUNC_TICK, UNIT_FPU, 8'h00, 4'h0));
    add_width(4'd0);
    add_typed(mk_item(FUNC_ENQUEUE, UNIT_ALU0, 8'h5A, 4'h0),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_TICK, UNIT_FPU, 8'h00, 4'h0),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_width(4'd15);
    add_typed(mk_item(FUNC_CREDIT, UNIT_ALU0, 8'h00, 4'hF),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_CREDIT, UNIT_ALU1, 8'h00, 4'hF),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_CREDIT, UNIT_BRANCH, 8'h00, 4'hF),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_typed(mk_item(FUNC_CREDIT, UNIT_LSU, 8'h00, 4'hF),
              quiet_result(STALL_NONE, 5'd0, 1'b0));
    add_item(mk_item(FUNC_ENQUEUE, UNIT_ALU1, 8'h3C, 4'h0));
    add_item(mk_item(FUNC_ENQUEUE, UNIT_BRANCH, 8'hC3, 4'h0));
    add_item(mk_item(FUNC_ENQUEUE, UNIT_LSU, 8'h0F, 4'h0));
    add_item(mk_item(FUNC_ENQUEUE, UNIT_FPU, 8'hF0, 4'h0));
    add_item(mk_item(FUNC_TICK, UNIT_FPU, 8'h00, 4'h0));
    add_item(mk_item(FUNC_FLUSH, UNIT_FPU, 8'h00, 4'h0));
    add_width(4'd1);
    add_item(mk_item(FUNC_CREDIT, UNIT_ALU0, 8'h00, 4'h0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain_results();
        write_width(directed_rows[i].width);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      drain_results();
      quota = 60;
      send_idle_pct = 27;
      case (p)
        0: begin
          w = 4'd1;
          credit_pct = 15;
          ready_idle_pct <= 27;
        end
        1: begin
          w = 4'd8;
          credit_pct = 25;
          send_idle_pct = 0;
          ready_idle_pct <= 0;
        end
        2: begin
          w = 4'd15;
          credit_pct = 25;
          quota = 40;
          ready_idle_pct <= 27;
        end
        3: begin
          w = 4'd3;
          credit_pct = 20;
          send_idle_pct = 0;
          ready_idle_pct <= 27;
        end
        4: begin
          w = 4'd0;
          credit_pct = 20;
          quota = 30;
          ready_idle_pct <= 27;
        end
        default: begin
          w = 4'd5;
          credit_pct = 30;
          ready_idle_pct <= 27;
        end
      endcase
      write_width(w);
      if (p == 2) begin
        // Pour large credit returns into one pool to push it towards saturation.
        pool = 3'($urandom_range(5));
        repeat (24)
          send_item(mk_item(FUNC_CREDIT, pool, 8'($urandom_range(255)),
                            4'($urandom_range(8, 15))), 1'b0, none);
      end
      if (p == 3) hold_request <= 1'b1;
      done = 0;
      while (done < quota) begin
        if ($urandom_range(99) < 4) begin
          burst = $urandom_range(14, 19);
          repeat (burst)
            send_item(mk_item(FUNC_ENQUEUE, 3'($urandom_range(7)), 8'($urandom_range(255)),
                              4'($urandom_range(15))), 1'b0, none);
          done += burst;
        end else begin
          send_item(random_item(credit_pct), 1'b0, none);
          done++;
        end
      end
    end

    drain_results();
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Sent %0d transactions over dispatch widths 0, 1, 3, 4, 5, 8 and 15;",
             items_sent);
    $display("received %0d results, dispatched %0d instructions, %0d enqueues dropped,",
             results_seen, dispatched_seen, drops_seen);
    $display("%0d stalled results, peak occupancy %0d.", stalled_seen, peak_occupancy);
    if (mismatch_count == 0) begin
      $display("PASS credit_based_instruction_dispatch_core");
    end else begin
      $display("FAIL credit_based_instruction_dispatch_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/cbid_pkg.sv
design/cbid_stream_if.sv
design/cbid_ram.sv
design/credit_based_instruction_dispatch_core.sv
tb/credit_based_instruction_dispatch_core_test.sv
